// File: rtl/core/ldnp_pkg.sv
// Shared types, constants and codes for the line dictionary nibble packer.
`timescale 1ns / 1ps

package ldnp_pkg;

   // Default dictionary size and letter capacity of one line.
   localparam int UNIQUE_LETTERS_DEF = 16;
   localparam int ROW_LETTERS_DEF    = 80;

   // Line separator after reset (line feed).
   localparam logic [7:0] SEP_RESET = 8'd10;

   // Error codes carried on the result channel.
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_DICT_FULL = 2'd1,
      ERR_ODD       = 2'd2,
      ERR_TOO_LONG  = 2'd3
   } err_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LETTERS,
      ST_PAIRS
   } state_type;

   // Source of the byte loaded into the output register.
   typedef enum logic [1:0] {
      SEL_COUNT,
      SEL_LETTER,
      SEL_PAIR,
      SEL_ERROR
   } out_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        letter_take;
      logic        clear_line;
      logic        idx_clear;
      logic        idx_inc;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic    is_sep;
      err_type err;
      logic    uniq_zero;
      logic    pair_zero;
      logic    last_letter;
      logic    last_pair;
      logic    out_free;
   } status_type;

endpackage

// File: rtl/core/ldnp_ctrl.sv
// Controller state machine: input acceptance and sequencing of line records.
`timescale 1ns / 1ps

module ldnp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ldnp_pkg::status_type status,
   output ldnp_pkg::cmd_type    cmd
);

   ldnp_pkg::state_type state_ff;
   ldnp_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ldnp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd.letter_take = 1'b0;
      cmd.clear_line  = 1'b0;
      cmd.idx_clear   = 1'b0;
      cmd.idx_inc     = 1'b0;
      cmd.out_load    = 1'b0;
      cmd.out_sel     = ldnp_pkg::SEL_COUNT;
      case (state_ff)
         ldnp_pkg::ST_IDLE: begin
            // A byte is taken only when the output register can take a result.
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (status.err != ldnp_pkg::ERR_NONE) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_sel    = ldnp_pkg::SEL_ERROR;
                  cmd.clear_line = 1'b1;
               end else if (status.is_sep) begin
                  cmd.out_load  = 1'b1;
                  cmd.out_sel   = ldnp_pkg::SEL_COUNT;
                  cmd.idx_clear = 1'b1;
                  if (status.uniq_zero && status.pair_zero) begin
                     cmd.clear_line = 1'b1;
                  end else if (status.uniq_zero) begin
                     state_in = ldnp_pkg::ST_PAIRS;
                  end else begin
                     state_in = ldnp_pkg::ST_LETTERS;
                  end
               end else begin
                  cmd.letter_take = 1'b1;
               end
            end
         end
         ldnp_pkg::ST_LETTERS: begin
            // Dictionary letters in first-seen order.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = ldnp_pkg::SEL_LETTER;
               if (status.last_letter) begin
                  cmd.idx_clear = 1'b1;
                  if (status.pair_zero) begin
                     cmd.clear_line = 1'b1;
                     state_in       = ldnp_pkg::ST_IDLE;
                  end else begin
                     state_in = ldnp_pkg::ST_PAIRS;
                  end
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         ldnp_pkg::ST_PAIRS: begin
            // Packed bytes, read from the pair memory one a cycle when not stalled.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = ldnp_pkg::SEL_PAIR;
               if (status.last_pair) begin
                  cmd.idx_clear  = 1'b1;
                  cmd.clear_line = 1'b1;
                  state_in       = ldnp_pkg::ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = ldnp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/ldnp_dp.sv
// Datapath: dictionary, pair memory, line counters and the output register.
`timescale 1ns / 1ps

module ldnp_dp #(
   parameter int UNIQUE_LETTERS = ldnp_pkg::UNIQUE_LETTERS_DEF,
   parameter int ROW_LETTERS    = ldnp_pkg::ROW_LETTERS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_data_byte,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_out_byte,
   output logic [1:0]           rsp_error_code,
   output logic                 rsp_last,
   input  ldnp_pkg::cmd_type    cmd,
   output ldnp_pkg::status_type status
);

   localparam int PAIR_CAP = ROW_LETTERS / 2;
   localparam int U_AW     = $clog2(UNIQUE_LETTERS);
   localparam int U_CW     = $clog2(UNIQUE_LETTERS + 1);
   localparam int P_AW     = (PAIR_CAP > 1) ? $clog2(PAIR_CAP) : 1;
   localparam int P_CW     = $clog2(PAIR_CAP + 1);
   localparam int IDX_W    = (U_AW > P_AW) ? U_AW : P_AW;
   localparam int CMP_W    = ((U_CW > P_CW) ? U_CW : P_CW) + 1;

   // Configuration and line state.
   logic [7:0]      sep_ff;
   logic [7:0]      letter_table_ff [UNIQUE_LETTERS];
   logic [7:0]      pair_mem [PAIR_CAP];
   logic [7:0]      pair_rd_ff;
   logic [U_CW-1:0] unique_count_ff;
   logic [P_CW-1:0] pair_count_ff;
   logic            half_pending_ff;
   logic [3:0]      high_nibble_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;

   // Output register.
   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff;
   logic [1:0]      rsp_err_ff;
   logic            rsp_last_ff;

   logic            hit;
   logic [U_AW-1:0] hit_idx;
   logic [3:0]      code;
   logic            is_sep;
   logic            dict_full;
   logic            pairs_full;
   ldnp_pkg::err_type err;
   logic            last_letter;
   logic            last_pair;
   logic [7:0]      out_byte;
   logic            out_last;

   // Parallel match of the byte against the dictionary entries in use.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < UNIQUE_LETTERS; i++) begin
         if ((U_CW'(i) < unique_count_ff) && (letter_table_ff[i] == req_data_byte)) begin
            hit     = 1'b1;
            hit_idx = hit_idx | U_AW'(i);
         end
      end
   end

   assign code = hit ? 4'(hit_idx) : 4'(unique_count_ff[U_AW-1:0]);

   // Classification of the offered byte; too long is checked before full.
   assign is_sep     = (req_data_byte == sep_ff);
   assign dict_full  = (unique_count_ff == U_CW'(UNIQUE_LETTERS));
   assign pairs_full = (pair_count_ff >= P_CW'(PAIR_CAP));

   always_comb begin
      if (is_sep) begin
         err = half_pending_ff ? ldnp_pkg::ERR_ODD : ldnp_pkg::ERR_NONE;
      end else if (!half_pending_ff && pairs_full) begin
         err = ldnp_pkg::ERR_TOO_LONG;
      end else if (!hit && dict_full) begin
         err = ldnp_pkg::ERR_DICT_FULL;
      end else begin
         err = ldnp_pkg::ERR_NONE;
      end
   end

   // End-of-section flags for the record sequencer.
   assign last_letter = (CMP_W'(idx_ff) + CMP_W'(1)) == CMP_W'(unique_count_ff);
   assign last_pair   = (CMP_W'(idx_ff) + CMP_W'(1)) == CMP_W'(pair_count_ff);

   assign status.is_sep      = is_sep;
   assign status.err         = err;
   assign status.uniq_zero   = (unique_count_ff == '0);
   assign status.pair_zero   = (pair_count_ff == '0);
   assign status.last_letter = last_letter;
   assign status.last_pair   = last_pair;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   // Line separator register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= ldnp_pkg::SEP_RESET;
      end else if (csr_wr_en) begin
         sep_ff <= csr_wr_data;
      end
   end

   // Dictionary entries are written when a new letter is seen.
   always_ff @(posedge clock) begin
      if (cmd.letter_take && !hit) begin
         letter_table_ff[unique_count_ff[U_AW-1:0]] <= req_data_byte;
      end
   end

   // Pair memory: written when a pair completes, read one entry ahead.
   always_ff @(posedge clock) begin
      if (cmd.letter_take && half_pending_ff && !pairs_full) begin
         pair_mem[pair_count_ff[P_AW-1:0]] <= {high_nibble_ff, code};
      end
      pair_rd_ff <= pair_mem[idx_in[P_AW-1:0]];
   end

   // Line counters and the waiting first letter.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_line) begin
         unique_count_ff <= '0;
         pair_count_ff   <= '0;
         half_pending_ff <= 1'b0;
         high_nibble_ff  <= '0;
      end else if (cmd.letter_take) begin
         if (!hit) begin
            unique_count_ff <= unique_count_ff + U_CW'(1);
         end
         if (!half_pending_ff) begin
            high_nibble_ff  <= code;
            half_pending_ff <= 1'b1;
         end else begin
            if (!pairs_full) begin
               pair_count_ff <= pair_count_ff + P_CW'(1);
            end
            half_pending_ff <= 1'b0;
            high_nibble_ff  <= '0;
         end
      end
   end

   // Record index shared by the letter and pair sections.
   always_comb begin
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // Byte and last flag of the result being loaded.
   always_comb begin
      case (cmd.out_sel)
         ldnp_pkg::SEL_COUNT: begin
            out_byte = 8'(unique_count_ff);
            out_last = (unique_count_ff == '0) && (pair_count_ff == '0);
         end
         ldnp_pkg::SEL_LETTER: begin
            out_byte = letter_table_ff[idx_ff[U_AW-1:0]];
            out_last = last_letter && (pair_count_ff == '0);
         end
         ldnp_pkg::SEL_PAIR: begin
            out_byte = pair_rd_ff;
            out_last = last_pair;
         end
         default: begin
            out_byte = 8'd0;
            out_last = 1'b1;
         end
      endcase
   end

   // Output register; a result stays until the receiver takes the transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_byte_ff <= out_byte;
         rsp_err_ff  <= (cmd.out_sel == ldnp_pkg::SEL_ERROR) ? err : ldnp_pkg::ERR_NONE;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_error_code = rsp_err_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: rtl/core/line_dictionary_nibble_packer_core.sv
// Top level of the line dictionary nibble packer: controller plus datapath.
// Usage:
// Bytes of a text stream arrive on the req_ channel (valid/ready), one per
// transfer. Each line builds its own dictionary of up to UNIQUE_LETTERS
// letters and packs letter codes in pairs, the first in the high nibble.
// When the line separator (csr_wr_data, written with csr_wr_en, reset 10)
// arrives, the rsp_ channel delivers the unique count, the dictionary
// letters and the packed bytes, with rsp_last on the final byte. A full
// dictionary, an odd letter count or an overlong line gives one result with
// an error code and rsp_last set, and the line starts afresh.
// Throughput: a letter is taken every cycle while the output register is
// free, matched against all entries at once. A separator's record leaves
// one result per cycle unless stalled (count, U letters, P packed bytes),
// the pair memory read one entry ahead; input is held off for that time.
// Latency: a result is visible the cycle after the transfer that caused it.
// Reset clears the line state and the output register; nothing needs to
// be swept. A stalled receiver holds the result in place and the block
// takes no byte at all, letter or not, until the register is free.
`timescale 1ns / 1ps

module line_dictionary_nibble_packer_core #(
   parameter int UNIQUE_LETTERS = ldnp_pkg::UNIQUE_LETTERS_DEF,
   parameter int ROW_LETTERS    = ldnp_pkg::ROW_LETTERS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   ldnp_pkg::cmd_type    cmd;
   ldnp_pkg::status_type status;

   // Sequencer.
   ldnp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and result path.
   ldnp_dp #(
      .UNIQUE_LETTERS (UNIQUE_LETTERS),
      .ROW_LETTERS    (ROW_LETTERS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last),
      .cmd            (cmd),
      .status         (status)
   );

`ifndef SYNTHESIS
   // An error result always closes its record.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ldnp_pkg::ERR_NONE) |-> rsp_last)
      else $error("error result without last");

   // An error result carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ldnp_pkg::ERR_NONE) |-> (rsp_out_byte == 8'd0))
      else $error("error result with non-zero byte");

   // Input is only taken while the output register can accept a result.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("input taken while output register is blocked");
`endif

endmodule

// File: test/line_dictionary_nibble_packer_core_tb.sv
// Self-checking testbench for the line dictionary nibble packer core.
`timescale 1ns / 1ps

module line_dictionary_nibble_packer_core_tb;

   localparam int DICT_SIZE      = ldnp_pkg::UNIQUE_LETTERS_DEF;
   localparam int PAIR_CAP       = ldnp_pkg::ROW_LETTERS_DEF / 2;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_BYTES   = 26;

   // One byte of a line record or one error report.
   typedef struct packed {
      logic [7:0]        out_byte;
      ldnp_pkg::err_type error_code;
      logic              last;
   } line_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_error_code;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = ldnp_pkg::SEP_RESET;

   // Expected line output, oldest first.
   line_result_type line_output_q[$];
   int fail_count = 0;
   int stall_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // Predicted state of the packer.
   logic [7:0] sep_value = ldnp_pkg::SEP_RESET;
   logic [7:0] dict_letters[DICT_SIZE];
   int         dict_used = 0;
   logic [7:0] packed_pairs[PAIR_CAP];
   int         pairs_used = 0;
   logic       half_waiting = 1'b0;
   logic [3:0] waiting_code = 4'd0;

   line_dictionary_nibble_packer_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #1 clock = ~clock;

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Nothing transferred for too long means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Compare every result transfer with the oldest expectation.
   always @(posedge clock) begin
      line_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_output_q.size() == 0) begin
            $error("unexpected result: out_byte %0d error_code %0d last %0d",
                   rsp_out_byte, rsp_error_code, rsp_last);
            fail_count++;
         end else begin
            want = line_output_q.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0d, got %0d", want.out_byte, rsp_out_byte);
               fail_count++;
            end
            if (rsp_error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code,
                      rsp_error_code);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   function automatic void clear_line_state();
      dict_used    = 0;
      pairs_used   = 0;
      half_waiting = 1'b0;
      waiting_code = 4'd0;
   endfunction

   function automatic void expect_result(input logic [7:0] b,
                                         input ldnp_pkg::err_type code,
                                         input logic is_last);
      line_result_type r;
      r.out_byte   = b;
      r.error_code = code;
      r.last       = is_last;
      line_output_q.push_back(r);
   endfunction

   function automatic void expect_line_error(input ldnp_pkg::err_type code);
      clear_line_state();
      expect_result(8'd0, code, 1'b1);
   endfunction

   // Dictionary index of a letter, adding it when there is room; -1 when full.
   function automatic int dict_code(input logic [7:0] c);
      for (int i = 0; i < dict_used; i++) begin
         if (dict_letters[i] == c) return i;
      end
      if (dict_used < DICT_SIZE) begin
         dict_letters[dict_used] = c;
         dict_used++;
         return dict_used - 1;
      end
      return -1;
   endfunction

   // Update the predicted line state with one accepted byte.
   function automatic void predict_line_byte(input logic [7:0] c);
      int code;
      int total;
      int k;
      if (c == sep_value) begin
         if (half_waiting) begin
            expect_line_error(ldnp_pkg::ERR_ODD);
         end else begin
            total = 1 + dict_used + pairs_used;
            k = 0;
            expect_result(8'(dict_used), ldnp_pkg::ERR_NONE, k == total - 1);
            k++;
            for (int i = 0; i < dict_used; i++) begin
               expect_result(dict_letters[i], ldnp_pkg::ERR_NONE, k == total - 1);
               k++;
            end
            for (int i = 0; i < pairs_used; i++) begin
               expect_result(packed_pairs[i], ldnp_pkg::ERR_NONE, k == total - 1);
               k++;
            end
            clear_line_state();
         end
      end else if (!half_waiting) begin
         // The length check takes precedence over the dictionary check.
         if (pairs_used >= PAIR_CAP) begin
            expect_line_error(ldnp_pkg::ERR_TOO_LONG);
         end else begin
            code = dict_code(c);
            if (code < 0) begin
               expect_line_error(ldnp_pkg::ERR_DICT_FULL);
            end else begin
               waiting_code = 4'(code);
               half_waiting = 1'b1;
            end
         end
      end else begin
         code = dict_code(c);
         if (code < 0) begin
            expect_line_error(ldnp_pkg::ERR_DICT_FULL);
         end else begin
            packed_pairs[pairs_used] = {waiting_code, 4'(code)};
            pairs_used++;
            half_waiting = 1'b0;
            waiting_code = 4'd0;
         end
      end
   endfunction

   // Offer one byte, idling first as the phase asks, and wait for its transfer.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_line_byte(b);
   endtask

   // Hold off the sender until every expected result has arrived.
   task automatic wait_for_line_output();
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_output_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] v);
      wait_for_line_output();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sep_value = v;
   endtask

   // Empty, odd, repeated-letter and extreme-value lines.
   task automatic test_short_lines();
      send_byte(ldnp_pkg::SEP_RESET);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(ldnp_pkg::SEP_RESET);
      send_byte("a");
      send_byte(ldnp_pkg::SEP_RESET);
      send_byte("a");
      send_byte("b");
      send_byte("a");
      send_byte("b");
      send_byte(ldnp_pkg::SEP_RESET);
      send_byte(8'h09);
      send_byte(8'h0B);
      send_byte(8'h0B);
      send_byte(8'h09);
      send_byte(ldnp_pkg::SEP_RESET);
   endtask

   // A new letter once the dictionary holds every slot, on both halves of a pair.
   task automatic test_dictionary_full();
      for (int i = 0; i < DICT_SIZE; i++) send_byte(8'(8'h41 + i));
      send_byte("z");
      for (int i = 0; i < DICT_SIZE; i++) send_byte(8'(8'h41 + i));
      send_byte(8'h41);
      send_byte("z");
      for (int i = 0; i < DICT_SIZE; i++) send_byte(8'(8'h41 + i));
      send_byte(ldnp_pkg::SEP_RESET);
   endtask

   // A line at full capacity, then one letter too many.
   task automatic test_line_too_long();
      for (int i = 0; i < 2 * PAIR_CAP; i++) send_byte(8'(8'h30 + i % DICT_SIZE));
      send_byte(ldnp_pkg::SEP_RESET);
      for (int i = 0; i < 2 * PAIR_CAP; i++) send_byte(8'(8'h30 + i % DICT_SIZE));
      // A new letter here is refused for length, not for the dictionary.
      send_byte(8'hEE);
      send_byte(ldnp_pkg::SEP_RESET);
   endtask

   // The separator at both ends of its range; the old separator becomes a letter.
   task automatic test_separator_extremes();
      write_separator(8'h00);
      send_byte(8'hFF);
      send_byte(ldnp_pkg::SEP_RESET);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      write_separator(8'hFF);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // One line with random content and shape; returns the number of bytes sent.
   task automatic send_random_line(output int sent);
      int unsigned shape;
      int unsigned alpha;
      int unsigned base;
      int unsigned n_letters;
      logic [7:0]  c;
      shape = $urandom_range(0, 99);
      alpha = $urandom_range(1, DICT_SIZE + 2);
      base  = $urandom_range(0, 255);
      if (shape < 75) n_letters = 2 * $urandom_range(0, 8);
      else if (shape < 85) n_letters = 2 * $urandom_range(9, PAIR_CAP);
      else if (shape < 90) n_letters = $urandom_range(2 * PAIR_CAP - 2, 2 * PAIR_CAP + 4);
      else n_letters = 2 * $urandom_range(0, 6) + 1;
      sent = 0;
      for (int unsigned i = 0; i < n_letters; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            // Occasional noise, which may itself end the line.
            c = 8'($urandom_range(0, 255));
         end else begin
            c = 8'(base + $urandom_range(0, alpha - 1));
            if (c == sep_value) c = c + 8'd1;
         end
         send_byte(c);
         sent++;
      end
      // A few lines run on into the next one.
      if (shape < 97 || shape >= 99) begin
         send_byte(sep_value);
         sent++;
      end
   endtask

   task automatic test_random_lines(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input logic [7:0] sep, input bit pause_midway);
      int total;
      int sent;
      write_separator(sep);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      total = 0;
      while (total < RANDOM_BYTES) begin
         send_random_line(sent);
         total += sent;
         if (pause_midway && total >= RANDOM_BYTES / 2) begin
            wait_for_line_output();
            pause_midway = 1'b0;
         end
      end
   endtask

   // Letters left without a separator must never produce output.
   task automatic test_unterminated_tail();
      send_byte("x");
      send_byte("y");
      send_byte("x");
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_lines();
      test_dictionary_full();
      test_line_too_long();
      test_separator_extremes();
      test_random_lines(0, 0, ldnp_pkg::SEP_RESET, 1'b1);
      test_random_lines(68, 0, 8'($urandom_range(0, 255)), 1'b0);
      test_random_lines(0, 68, 8'($urandom_range(0, 255)), 1'b0);
      test_random_lines(14, 14, ldnp_pkg::SEP_RESET, 1'b0);
      test_unterminated_tail();

      wait_for_line_output();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/ldnp_pkg.sv
rtl/core/ldnp_ctrl.sv
rtl/core/ldnp_dp.sv
rtl/core/line_dictionary_nibble_packer_core.sv
test/line_dictionary_nibble_packer_core_tb.sv
